// ===== sv/cpd_pkg.sv =====
package cpd_pkg;

  // datapath sizes
  localparam int unsigned STEPS        = 16;
  localparam int unsigned SAMPLE_WIDTH = 36;
  localparam int unsigned PHASE_WIDTH  = 18;
  localparam int unsigned STEP_IDX_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned TURN_LEN     = 20;
  localparam int unsigned TURN_IDX_W   = $clog2(TURN_LEN);

  // arctangent per turn scaled to 2^32, entry 0 unused
  localparam logic [31:0] TURN32 [TURN_LEN] = '{
    32'd0,        32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,   32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,    32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

  // state handed from cell to cell
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] cq;
    logic [SAMPLE_WIDTH:0]   si;
    logic [PHASE_WIDTH-1:0]  ang;
    logic                    pos;
  } cpd_data_t;

  // arctangent table entry, first entry just under a quarter turn
  function automatic logic [PHASE_WIDTH-1:0] atan_entry(input logic [STEP_IDX_W-1:0] idx);
    logic [32:0] sum;
    logic [32:0] shr;
    sum = '0;
    shr = '0;
    if (idx == '0) begin
      atan_entry = PHASE_WIDTH'((1 << (PHASE_WIDTH - 2)) - 2);
    end else if (int'(idx) < TURN_LEN) begin
      sum = {1'b0, TURN32[TURN_IDX_W'(idx)]} + 33'(1 << (31 - PHASE_WIDTH));
      shr = sum >> (32 - PHASE_WIDTH);
      atan_entry = shr[PHASE_WIDTH-1:0];
    end else begin
      atan_entry = '0;
    end
  endfunction

endpackage

// ===== sv/cpd_prep.sv =====
module cpd_prep (
  input  logic [cpd_pkg::SAMPLE_WIDTH-1:0] cos_part_i,
  input  logic [cpd_pkg::SAMPLE_WIDTH-1:0] sin_part_i,
  output cpd_pkg::cpd_data_t               data_o
);

  localparam logic [cpd_pkg::PHASE_WIDTH-1:0] HalfTurn =
    cpd_pkg::PHASE_WIDTH'(1 << (cpd_pkg::PHASE_WIDTH - 1));
  localparam logic [cpd_pkg::PHASE_WIDTH-1:0] One = cpd_pkg::PHASE_WIDTH'(1);
  localparam logic [cpd_pkg::PHASE_WIDTH-1:0] Two = cpd_pkg::PHASE_WIDTH'(2);

  logic cneg;
  logic sneg;
  logic [cpd_pkg::PHASE_WIDTH-1:0] base_ang;

  assign cneg = cos_part_i[cpd_pkg::SAMPLE_WIDTH-1];
  assign sneg = sin_part_i[cpd_pkg::SAMPLE_WIDTH-1];

  // starting angle from the quadrant
  always_comb begin
    base_ang = (sneg ? HalfTurn : '0) + One;
    if (cneg != sneg) begin
      base_ang = base_ang + HalfTurn - Two;
    end
  end

  // one's complement magnitudes
  always_comb begin
    data_o.cq  = cneg ? ~cos_part_i : cos_part_i;
    data_o.si  = {1'b0, (sneg ? ~sin_part_i : sin_part_i)};
    data_o.ang = base_ang;
    data_o.pos = (cneg == sneg);
  end

endmodule

// ===== sv/cpd_cell.sv =====
module cpd_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [cpd_pkg::STEP_IDX_W-1:0]       step_idx_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  cpd_pkg::cpd_data_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cpd_pkg::cpd_data_t                   out_data_o
);

  logic                                valid_q;
  cpd_pkg::cpd_data_t                  data_q;
  cpd_pkg::cpd_data_t                  data_d;
  logic [cpd_pkg::SAMPLE_WIDTH:0]      shifted;
  logic [cpd_pkg::SAMPLE_WIDTH-1:0]    c_trial;
  logic [cpd_pkg::SAMPLE_WIDTH:0]      s_trial;
  logic [cpd_pkg::PHASE_WIDTH-1:0]     entry;
  logic                                take;
  logic                                load;

  assign entry = cpd_pkg::atan_entry(step_idx_i);

  // trial step
  assign shifted = in_data_i.si >> {step_idx_i, 1'b0};
  assign c_trial = in_data_i.cq + shifted[cpd_pkg::SAMPLE_WIDTH-1:0];
  assign s_trial = in_data_i.si - {1'b0, in_data_i.cq};
  assign take    = ~s_trial[cpd_pkg::SAMPLE_WIDTH];

  // restoring update, first step is the quarter-turn swap
  always_comb begin
    data_d.cq  = in_data_i.cq;
    data_d.si  = {in_data_i.si[cpd_pkg::SAMPLE_WIDTH-1:0], 1'b0};
    data_d.ang = in_data_i.ang;
    data_d.pos = in_data_i.pos;
    if (take) begin
      data_d.ang = in_data_i.pos ? (in_data_i.ang + entry) : (in_data_i.ang - entry);
      if (step_idx_i == '0) begin
        data_d.cq  = in_data_i.si[cpd_pkg::SAMPLE_WIDTH-1:0];
        data_d.si  = {in_data_i.cq, 1'b0};
        data_d.pos = ~in_data_i.pos;
      end else begin
        data_d.cq = c_trial;
        data_d.si = {s_trial[cpd_pkg::SAMPLE_WIDTH-1:0], 1'b0};
      end
    end
  end

  // stage handshake
  assign in_ready_o = ~valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/cordic_phase_detector_core.sv =====
// a request is registered in every cell of the chain before its result reaches the output
// throughput: one sample per cycle unless the output stalls, one pipeline cell per cordic step
// a stalled output holds the chain; bubbles inside the chain are filled
// reset: asynchronous, active low; clears every stage valid bit
module cordic_phase_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cpd_pkg::SAMPLE_WIDTH-1:0]     cos_part_i,
  input  logic [cpd_pkg::SAMPLE_WIDTH-1:0]     sin_part_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cpd_pkg::PHASE_WIDTH-1:0]      phase_o
);

  logic               valid_w [cpd_pkg::STEPS+1];
  logic               ready_w [cpd_pkg::STEPS+1];
  cpd_pkg::cpd_data_t data_w  [cpd_pkg::STEPS+1];

  // quadrant and magnitude conditioning
  cpd_prep u_prep (
    .cos_part_i (cos_part_i),
    .sin_part_i (sin_part_i),
    .data_o     (data_w[0])
  );

  assign valid_w[0] = in_valid_i;
  assign in_ready_o = ready_w[0];

  // chain of cordic cells
  for (genvar k = 0; k < cpd_pkg::STEPS; k++) begin : g_cell
    cpd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_idx_i  (cpd_pkg::STEP_IDX_W'(k)),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .in_data_i   (data_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .out_data_o  (data_w[k+1])
    );
  end

  assign ready_w[cpd_pkg::STEPS] = out_ready_i;
  assign out_valid_o = valid_w[cpd_pkg::STEPS];
  assign phase_o     = data_w[cpd_pkg::STEPS].ang;

  // a blocked input means every stage is full
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with output empty");

  // a taken output frees the whole chain
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("ready did not propagate through chain");

  // a stalled first cell keeps its request
  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w[1] && !ready_w[1]) |=> (valid_w[1] && $stable(data_w[1])))
    else $error("stalled cell lost its request");

endmodule
